// File: rtl/mmc_pkg.sv
// ----------------------------------------------------------------------------
// mmc_pkg: shared types and constants for the MMC SPI-mode host sequencer
// Phase and operation codes, SPI command framing bytes and command builders.
// ----------------------------------------------------------------------------
package mmc_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_WAKE  = 4'd1,
        PH_CMD   = 4'd2,
        PH_POLL  = 4'd3,
        PH_TOKEN = 4'd4,
        PH_DATA  = 4'd5,
        PH_CRC   = 4'd6
    } t_phase;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_SET_LEN = 2'd1,
        OP_READ    = 2'd2,
        OP_CSD_CID = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_BLOCK_LENGTH = 1'b0,
        CFG_POLL_LIMIT   = 1'b1
    } t_cfg_index;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_SEND_OP   = 6'd1;
    localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
    localparam logic [5:0] CMD_SEND_CID  = 6'd10;
    localparam logic [5:0] CMD_SET_BLEN  = 6'd16;
    localparam logic [5:0] CMD_READ_ONE  = 6'd17;

    localparam logic [7:0] CMD_START     = 8'h40;
    localparam logic [7:0] CRC_GO_IDLE   = 8'h95;
    localparam logic [7:0] FILL_BYTE     = 8'hFF;
    localparam logic [7:0] DATA_TOKEN    = 8'hFE;
    localparam logic [7:0] R1_IDLE       = 8'h01;
    localparam logic [7:0] R1_READY      = 8'h00;

    localparam int         WAKE_BYTES    = 10;
    localparam logic [12:0] REG_BYTES    = 13'd16;
    localparam logic [12:0] FRAME_BYTES  = 13'd6;

    localparam logic [12:0] BLOCK_LENGTH_RST = 13'd512;
    localparam logic [7:0]  POLL_LIMIT_RST   = 8'd10;

    // first byte of a command frame
    function automatic logic [7:0] cmd_head(input logic [5:0] idx);
        cmd_head = CMD_START | {2'b00, idx};
    endfunction

    // full six-byte frame: head, big-endian argument, crc
    function automatic logic [47:0] cmd_frame(input logic [5:0] idx,
                                              input logic [31:0] arg);
        logic [7:0] crc;
        crc = (idx == CMD_GO_IDLE) ? CRC_GO_IDLE : FILL_BYTE;
        cmd_frame = {cmd_head(idx), arg, crc};
    endfunction

endpackage

// File: rtl/mmc_spi_host_sequencer.sv
// ----------------------------------------------------------------------------
// mmc_spi_host_sequencer: byte-level MMC SPI-mode host sequencer
// Frames commands, polls R1, runs init, CMD16, block reads and CSD/CID reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries either an operation
//   request (i_command = 0, i_operation, i_block_address) or the report of a
//   finished SPI byte exchange (i_command = 1, i_received_byte).
//   Output channel (o_out_valid / i_out_stall) returns one result per input
//   transfer: next byte to shift, chip select, optional payload byte,
//   done flag and last R1 byte.
//   The result is registered: a transfer accepted at one edge shows its
//   result after that edge. One transfer per cycle is sustained while the
//   receiver does not stall; the single result register is the only
//   buffering, so it refills in the cycle it is taken. When the receiver
//   stalls, the result holds and o_in_stall rises until the result is taken.
//   Configuration writes (i_cfg_wr_en) land at the clock edge; index 0 is the
//   block length, index 1 the R1 poll limit. Write only while idle.
//   Synchronous reset returns to idle with the select state cleared (the
//   o_card_select register is not reset), block length 512 and poll limit 10.
// ----------------------------------------------------------------------------
module mmc_spi_host_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_block_address,
    input  logic [7:0]  i_received_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_shift_valid,
    output logic [7:0]  o_shift_byte,
    output logic        o_card_select,
    output logic        o_data_valid,
    output logic [7:0]  o_data_byte,
    output logic        o_operation_done,
    output logic [7:0]  o_response_code
);

    // configuration
    logic [12:0] r_block_length;
    logic [7:0]  r_poll_limit;

    // sequencer state
    mmc_pkg::t_phase r_phase, n_phase;
    mmc_pkg::t_op    r_cur_op, n_cur_op;
    logic [12:0]     r_byte_count, n_byte_count;
    logic [7:0]      r_poll_count, n_poll_count;
    logic [47:0]     r_cmd_frame, n_cmd_frame;
    logic            r_second, n_second;
    logic [7:0]      r_last_resp, n_last_resp;
    logic            r_select, n_select;

    // result register
    logic            r_out_valid;
    logic            r_shift_valid, n_shift_valid;
    logic [7:0]      r_shift_byte, n_shift_byte;
    logic            r_card_select;
    logic            r_data_valid, n_data_valid;
    logic [7:0]      r_data_byte, n_data_byte;
    logic            r_done, n_done;
    logic [7:0]      r_resp_code;

    // decode helpers
    logic            in_acc;
    logic            poll_more;
    logic [5:0]      frame_idx;
    logic [12:0]     data_len;
    logic [12:0]     data_cnt_inc;
    logic [7:0]      frame_byte;
    logic            start_cmd;
    logic [5:0]      start_idx;
    logic [31:0]     start_arg;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign poll_more    = i_received_byte[7] && ((r_poll_count - 8'd1) != 8'd0);
    assign frame_idx    = r_cmd_frame[45:40];
    assign data_len     = (r_cur_op == mmc_pkg::OP_CSD_CID) ? mmc_pkg::REG_BYTES
                                                            : r_block_length;
    assign data_cnt_inc = r_byte_count + 13'd1;

    always_comb begin
        unique case (r_byte_count[2:0])
            3'd1:    frame_byte = r_cmd_frame[39:32];
            3'd2:    frame_byte = r_cmd_frame[31:24];
            3'd3:    frame_byte = r_cmd_frame[23:16];
            3'd4:    frame_byte = r_cmd_frame[15:8];
            3'd5:    frame_byte = r_cmd_frame[7:0];
            default: frame_byte = mmc_pkg::FILL_BYTE;
        endcase
    end

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_cur_op     = r_cur_op;
        n_byte_count = r_byte_count;
        n_poll_count = r_poll_count;
        n_cmd_frame  = r_cmd_frame;
        n_second     = r_second;
        n_last_resp  = r_last_resp;
        n_select     = r_select;
        start_cmd    = 1'b0;
        start_idx    = mmc_pkg::CMD_GO_IDLE;
        start_arg    = 32'd0;

        if (!i_command) begin
            if (r_phase == mmc_pkg::PH_IDLE) begin
                n_cur_op = mmc_pkg::t_op'(i_operation);
                n_second = 1'b0;
                unique case (mmc_pkg::t_op'(i_operation))
                    mmc_pkg::OP_INIT: begin
                        n_select     = 1'b0;
                        n_phase      = mmc_pkg::PH_WAKE;
                        n_byte_count = 13'd1;
                    end
                    mmc_pkg::OP_SET_LEN: begin
                        start_cmd = 1'b1;
                        start_idx = mmc_pkg::CMD_SET_BLEN;
                        start_arg = {19'd0, r_block_length};
                    end
                    mmc_pkg::OP_READ: begin
                        start_cmd = 1'b1;
                        start_idx = mmc_pkg::CMD_READ_ONE;
                        start_arg = i_block_address;
                    end
                    default: begin
                        start_cmd = 1'b1;
                        start_idx = mmc_pkg::CMD_SEND_CSD;
                    end
                endcase
            end
        end else begin
            unique case (r_phase)
                mmc_pkg::PH_WAKE: begin
                    if (r_byte_count < 13'(mmc_pkg::WAKE_BYTES)) begin
                        n_byte_count = r_byte_count + 13'd1;
                    end else begin
                        start_cmd = 1'b1;
                        start_idx = mmc_pkg::CMD_GO_IDLE;
                    end
                end
                mmc_pkg::PH_CMD: begin
                    if (r_byte_count < mmc_pkg::FRAME_BYTES) begin
                        n_byte_count = r_byte_count + 13'd1;
                    end else begin
                        n_phase      = mmc_pkg::PH_POLL;
                        n_poll_count = r_poll_limit;
                    end
                end
                mmc_pkg::PH_POLL: begin
                    if (poll_more) begin
                        n_poll_count = r_poll_count - 8'd1;
                    end else begin
                        n_last_resp = i_received_byte;
                        if (frame_idx == mmc_pkg::CMD_GO_IDLE) begin
                            start_cmd = 1'b1;
                            start_idx = (i_received_byte == mmc_pkg::R1_IDLE)
                                      ? mmc_pkg::CMD_SEND_OP : mmc_pkg::CMD_GO_IDLE;
                        end else if (frame_idx == mmc_pkg::CMD_SEND_OP) begin
                            if (i_received_byte == mmc_pkg::R1_READY) begin
                                n_phase      = mmc_pkg::PH_IDLE;
                                n_byte_count = 13'd0;
                            end else begin
                                start_cmd = 1'b1;
                                start_idx = mmc_pkg::CMD_SEND_OP;
                            end
                        end else if (frame_idx == mmc_pkg::CMD_SET_BLEN) begin
                            n_phase      = mmc_pkg::PH_IDLE;
                            n_byte_count = 13'd0;
                        end else begin
                            n_phase = mmc_pkg::PH_TOKEN;
                        end
                    end
                end
                mmc_pkg::PH_TOKEN: begin
                    if (i_received_byte == mmc_pkg::DATA_TOKEN) begin
                        n_phase      = mmc_pkg::PH_DATA;
                        n_byte_count = 13'd0;
                    end
                end
                mmc_pkg::PH_DATA: begin
                    n_byte_count = data_cnt_inc;
                    if (data_cnt_inc == data_len) begin
                        n_phase      = mmc_pkg::PH_CRC;
                        n_byte_count = 13'd0;
                    end
                end
                mmc_pkg::PH_CRC: begin
                    if (r_byte_count == 13'd0) begin
                        n_byte_count = 13'd1;
                    end else if (r_cur_op == mmc_pkg::OP_CSD_CID && !r_second) begin
                        n_second  = 1'b1;
                        start_cmd = 1'b1;
                        start_idx = mmc_pkg::CMD_SEND_CID;
                    end else begin
                        // block read releases the card, the rest keep it selected
                        if (r_cur_op == mmc_pkg::OP_READ) begin
                            n_select = 1'b0;
                        end
                        n_phase      = mmc_pkg::PH_IDLE;
                        n_byte_count = 13'd0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (start_cmd) begin
            n_cmd_frame  = mmc_pkg::cmd_frame(start_idx, start_arg);
            n_select     = 1'b1;
            n_phase      = mmc_pkg::PH_CMD;
            n_byte_count = 13'd1;
        end
    end

    // result fields
    always_comb begin
        n_shift_valid = 1'b0;
        n_shift_byte  = 8'd0;
        n_data_valid  = 1'b0;
        n_data_byte   = 8'd0;
        n_done        = 1'b0;

        if (!i_command) begin
            if (r_phase == mmc_pkg::PH_IDLE) begin
                n_shift_valid = 1'b1;
                unique case (mmc_pkg::t_op'(i_operation))
                    mmc_pkg::OP_INIT:    n_shift_byte = mmc_pkg::FILL_BYTE;
                    mmc_pkg::OP_SET_LEN: n_shift_byte = mmc_pkg::cmd_head(mmc_pkg::CMD_SET_BLEN);
                    mmc_pkg::OP_READ:    n_shift_byte = mmc_pkg::cmd_head(mmc_pkg::CMD_READ_ONE);
                    default:             n_shift_byte = mmc_pkg::cmd_head(mmc_pkg::CMD_SEND_CSD);
                endcase
            end
        end else begin
            unique case (r_phase)
                mmc_pkg::PH_WAKE: begin
                    n_shift_valid = 1'b1;
                    n_shift_byte  = (r_byte_count < 13'(mmc_pkg::WAKE_BYTES))
                                  ? mmc_pkg::FILL_BYTE
                                  : mmc_pkg::cmd_head(mmc_pkg::CMD_GO_IDLE);
                end
                mmc_pkg::PH_CMD: begin
                    n_shift_valid = 1'b1;
                    n_shift_byte  = (r_byte_count < mmc_pkg::FRAME_BYTES)
                                  ? frame_byte : mmc_pkg::FILL_BYTE;
                end
                mmc_pkg::PH_POLL: begin
                    n_shift_valid = 1'b1;
                    n_shift_byte  = mmc_pkg::FILL_BYTE;
                    if (!poll_more) begin
                        if (frame_idx == mmc_pkg::CMD_GO_IDLE) begin
                            n_shift_byte = (i_received_byte == mmc_pkg::R1_IDLE)
                                ? mmc_pkg::cmd_head(mmc_pkg::CMD_SEND_OP)
                                : mmc_pkg::cmd_head(mmc_pkg::CMD_GO_IDLE);
                        end else if (frame_idx == mmc_pkg::CMD_SEND_OP) begin
                            if (i_received_byte == mmc_pkg::R1_READY) begin
                                n_shift_valid = 1'b0;
                                n_shift_byte  = 8'd0;
                                n_done        = 1'b1;
                            end else begin
                                n_shift_byte = mmc_pkg::cmd_head(mmc_pkg::CMD_SEND_OP);
                            end
                        end else if (frame_idx == mmc_pkg::CMD_SET_BLEN) begin
                            n_shift_valid = 1'b0;
                            n_shift_byte  = 8'd0;
                            n_done        = 1'b1;
                        end
                    end
                end
                mmc_pkg::PH_TOKEN: begin
                    n_shift_valid = 1'b1;
                    n_shift_byte  = mmc_pkg::FILL_BYTE;
                end
                mmc_pkg::PH_DATA: begin
                    n_shift_valid = 1'b1;
                    n_shift_byte  = mmc_pkg::FILL_BYTE;
                    n_data_valid  = 1'b1;
                    n_data_byte   = i_received_byte;
                end
                mmc_pkg::PH_CRC: begin
                    if (r_byte_count == 13'd0) begin
                        n_shift_valid = 1'b1;
                        n_shift_byte  = mmc_pkg::FILL_BYTE;
                    end else if (r_cur_op == mmc_pkg::OP_CSD_CID && !r_second) begin
                        n_shift_valid = 1'b1;
                        n_shift_byte  = mmc_pkg::cmd_head(mmc_pkg::CMD_SEND_CID);
                    end else begin
                        n_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= mmc_pkg::BLOCK_LENGTH_RST;
            r_poll_limit   <= mmc_pkg::POLL_LIMIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (mmc_pkg::t_cfg_index'(i_cfg_index))
                mmc_pkg::CFG_BLOCK_LENGTH: r_block_length <= i_cfg_data;
                default:                   r_poll_limit   <= i_cfg_data[7:0];
            endcase
        end
    end

    // sequencer state advances on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mmc_pkg::PH_IDLE;
            r_cur_op     <= mmc_pkg::OP_INIT;
            r_byte_count <= 13'd0;
            r_poll_count <= 8'd0;
            r_cmd_frame  <= 48'd0;
            r_second     <= 1'b0;
            r_last_resp  <= 8'd0;
            r_select     <= 1'b0;
        end else if (in_acc) begin
            r_phase      <= n_phase;
            r_cur_op     <= n_cur_op;
            r_byte_count <= n_byte_count;
            r_poll_count <= n_poll_count;
            r_cmd_frame  <= n_cmd_frame;
            r_second     <= n_second;
            r_last_resp  <= n_last_resp;
            r_select     <= n_select;
        end
    end

    // result register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_shift_valid <= n_shift_valid;
            r_shift_byte  <= n_shift_byte;
            r_card_select <= n_select;
            r_data_valid  <= n_data_valid;
            r_data_byte   <= n_data_byte;
            r_done        <= n_done;
            r_resp_code   <= n_last_resp;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_shift_valid    = r_shift_valid;
    assign o_shift_byte     = r_shift_byte;
    assign o_card_select    = r_card_select;
    assign o_data_valid     = r_data_valid;
    assign o_data_byte      = r_data_byte;
    assign o_operation_done = r_done;
    assign o_response_code  = r_resp_code;

endmodule
